FILE: src/fir16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir16_pkg: shared types and constants of the int16 fir filter
// widths, register codes and the control groups that pass between modules
// ----------------------------------------------------------------------------
package fir16_pkg;

  // filter geometry
  localparam int TAPS       = 16;
  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = COEF_WIDTH - 2;

  // sample and arithmetic widths
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_WIDTH;
  localparam int GRP_SIZE = 4;
  localparam int NUM_GRP  = (TAPS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W    = PROD_W + $clog2(GRP_SIZE);
  localparam int ACC_W    = PROD_W + $clog2(TAPS);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TCNT_W     = 5;
  localparam int NUM_BANKS  = 4;
  localparam int COEF_SLOT  = 16;
  localparam int BANK_W     = CFG_DATA_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_COEF_0    = 3'd1,
    REG_COEF_1    = 3'd2,
    REG_COEF_2    = 3'd3,
    REG_COEF_3    = 3'd4
  } cfg_reg_e;

  // per-cell control for one accepted beat
  typedef struct packed {
    logic shift;   // a beat is accepted: move history and capture product
    logic clear;   // batch start: history feeding this cell reads as zero
    logic use_tap; // this coefficient is within the tap count
  } cell_ctrl_t;

  // load enables of the summation stages
  typedef struct packed {
    logic ld_grp;
    logic ld_tot;
  } sum_ctrl_t;

endpackage

FILE: src/fir16_tap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir16_tap_cell: one tap of the filter chain
// holds one past sample, hands it to the next cell, registers coef * sample
// ----------------------------------------------------------------------------
module fir16_tap_cell (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  fir16_pkg::cell_ctrl_t                     ctrl_i,
  input  logic signed [fir16_pkg::SAMPLE_W-1:0]     smp_i,
  input  logic signed [fir16_pkg::COEF_WIDTH-1:0]   coef_i,
  output logic signed [fir16_pkg::SAMPLE_W-1:0]     smp_o,
  output logic signed [fir16_pkg::PROD_W-1:0]       prod_o
);

  logic signed [fir16_pkg::SAMPLE_W-1:0] tap;
  logic signed [fir16_pkg::SAMPLE_W-1:0] hist_q;
  logic signed [fir16_pkg::PROD_W-1:0]   prod_d, prod_q;

  // sample seen by this tap, zero at a batch start
  assign tap = ctrl_i.clear ? '0 : smp_i;

  always_comb begin
    if (ctrl_i.use_tap) begin
      prod_d = coef_i * tap;
    end else begin
      prod_d = '0;
    end
  end

  // history element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (ctrl_i.shift) begin
      hist_q <= tap;
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      prod_q <= prod_d;
    end
  end

  assign smp_o  = hist_q;
  assign prod_o = prod_q;

endmodule

FILE: src/fir16_sum_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir16_sum_tree: two-stage registered adder tree
// sums the tap products in groups of four, then sums the groups
// ----------------------------------------------------------------------------
module fir16_sum_tree (
  input  logic                                    clk_i,
  input  fir16_pkg::sum_ctrl_t                    ctrl_i,
  input  logic signed [fir16_pkg::PROD_W-1:0]     prod_i [fir16_pkg::TAPS],
  output logic signed [fir16_pkg::ACC_W-1:0]      sum_o
);

  logic signed [fir16_pkg::GRP_W-1:0] grp_d [fir16_pkg::NUM_GRP];
  logic signed [fir16_pkg::GRP_W-1:0] grp_q [fir16_pkg::NUM_GRP];
  logic signed [fir16_pkg::ACC_W-1:0] tot_d, tot_q;

  // group sums
  always_comb begin
    for (int g = 0; g < fir16_pkg::NUM_GRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < fir16_pkg::GRP_SIZE; k++) begin
        if (g * fir16_pkg::GRP_SIZE + k < fir16_pkg::TAPS) begin
          grp_d[g] = grp_d[g]
                   + fir16_pkg::GRP_W'(prod_i[g * fir16_pkg::GRP_SIZE + k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_grp) begin
      grp_q <= grp_d;
    end
  end

  // total over the groups
  always_comb begin
    tot_d = '0;
    for (int g = 0; g < fir16_pkg::NUM_GRP; g++) begin
      tot_d = tot_d + fir16_pkg::ACC_W'(grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_tot) begin
      tot_q <= tot_d;
    end
  end

  assign sum_o = tot_q;

endmodule

FILE: src/fir16_round_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir16_round_sat: output scaling stage
// rounds the sum half away from zero, saturates to int16, registers the beat
// ----------------------------------------------------------------------------
module fir16_round_sat (
  input  logic                                    clk_i,
  input  logic                                    load_i,
  input  logic signed [fir16_pkg::ACC_W-1:0]      acc_i,
  output logic signed [fir16_pkg::SAMPLE_W-1:0]   sample_o,
  output logic                                    clipped_o
);

  localparam int RND_W = fir16_pkg::ACC_W + 1;
  localparam int Q_W   = RND_W - fir16_pkg::FRAC_BITS;
  localparam logic [RND_W-1:0] HALF = RND_W'(1) << (fir16_pkg::FRAC_BITS - 1);
  localparam logic [Q_W-1:0] POS_MAX = Q_W'((1 << (fir16_pkg::SAMPLE_W - 1)) - 1);
  localparam logic [Q_W-1:0] NEG_MAG = Q_W'(1 << (fir16_pkg::SAMPLE_W - 1));
  localparam logic [fir16_pkg::SAMPLE_W-1:0] SAT_POS = {1'b0, {(fir16_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic [fir16_pkg::SAMPLE_W-1:0] SAT_NEG = {1'b1, {(fir16_pkg::SAMPLE_W-1){1'b0}}};

  logic                              neg;
  logic [fir16_pkg::ACC_W-1:0]       mag;
  logic [RND_W-1:0]                  rnd;
  logic [Q_W-1:0]                    q;
  logic [fir16_pkg::SAMPLE_W-1:0]    sample_d, sample_q;
  logic                              clip_d, clip_q;

  // magnitude, round, scale
  assign neg = acc_i[fir16_pkg::ACC_W-1];
  assign mag = neg ? (fir16_pkg::ACC_W'(0) - fir16_pkg::ACC_W'(acc_i))
                   : fir16_pkg::ACC_W'(acc_i);
  assign rnd = {1'b0, mag} + HALF;
  assign q   = rnd[RND_W-1:fir16_pkg::FRAC_BITS];

  // saturate to int16
  always_comb begin
    clip_d   = 1'b0;
    sample_d = q[fir16_pkg::SAMPLE_W-1:0];
    if (neg) begin
      if (q > NEG_MAG) begin
        clip_d   = 1'b1;
        sample_d = SAT_NEG;
      end else begin
        sample_d = fir16_pkg::SAMPLE_W'(0) - q[fir16_pkg::SAMPLE_W-1:0];
      end
    end else if (q > POS_MAX) begin
      clip_d   = 1'b1;
      sample_d = SAT_POS;
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= sample_d;
      clip_q   <= clip_d;
    end
  end

  assign sample_o  = sample_q;
  assign clipped_o = clip_q;

endmodule

FILE: src/fir_filter_int16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_int16: 16-tap direct-form fir filter on signed 16-bit samples
// chain of tap cells, registered adder tree and rounding output stage
// ----------------------------------------------------------------------------
// Takes one sample beat per clock while tready is high and returns one
// filtered beat per sample. A beat passes four register stages (tap products,
// group sums, total, output register); the first loads at the accepting edge.
// The throughput is one sample per cycle while the output is not stalled;
// each stage moves on as soon as the one after it is free, and while a
// finished beat waits at the output the input still takes up to three more
// beats before tready drops. The sum of
// coef[j] * x[n-j] over tap_count taps (Q2.14 coefficients) is rounded half
// away from zero, saturated to int16, and tuser flags the clip. tuser high on
// an input beat clears the sample history before that sample. Coefficients
// and tap_count apply to samples accepted after the write; write them only
// while no beat is in flight. The history resets to zero with no clearing
// pass, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module fir_filter_int16 (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input sample stream
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [fir16_pkg::SAMPLE_W-1:0]         s_axis_tdata_i,  // [15:0] sample_in
  input  logic                                   s_axis_tuser_i,  // [0] batch_start
  // output sample stream
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [fir16_pkg::SAMPLE_W-1:0]         m_axis_tdata_o,  // [15:0] sample_out
  output logic                                   m_axis_tuser_o,  // [0] clipped
  // register writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [fir16_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fir16_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  logic [fir16_pkg::TCNT_W-1:0] tap_count_q;
  logic [fir16_pkg::BANK_W-1:0] coef_bank_q [fir16_pkg::NUM_BANKS];
  logic [fir16_pkg::TCNT_W-1:0] taps_used;

  logic v_prod_q, v_grp_q, v_tot_q, v_out_q;
  logic ld_prod, ld_grp, ld_tot, ld_out;
  logic accept;

  fir16_pkg::cell_ctrl_t cell_ctrl [fir16_pkg::TAPS];
  fir16_pkg::sum_ctrl_t  sum_ctrl;

  logic signed [fir16_pkg::SAMPLE_W-1:0]   chain [fir16_pkg::TAPS+1];
  logic signed [fir16_pkg::COEF_WIDTH-1:0] coef  [fir16_pkg::TAPS];
  logic signed [fir16_pkg::PROD_W-1:0]     prod  [fir16_pkg::TAPS];
  logic signed [fir16_pkg::ACC_W-1:0]      sum;
  logic signed [fir16_pkg::SAMPLE_W-1:0]   sample_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= fir16_pkg::TCNT_W'(1);
      for (int b = 0; b < fir16_pkg::NUM_BANKS; b++) begin
        coef_bank_q[b] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fir16_pkg::REG_TAP_COUNT: tap_count_q    <= cfg_data_i[fir16_pkg::TCNT_W-1:0];
        fir16_pkg::REG_COEF_0:    coef_bank_q[0] <= cfg_data_i;
        fir16_pkg::REG_COEF_1:    coef_bank_q[1] <= cfg_data_i;
        fir16_pkg::REG_COEF_2:    coef_bank_q[2] <= cfg_data_i;
        fir16_pkg::REG_COEF_3:    coef_bank_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tap count clamped to 1 .. TAPS
  always_comb begin
    if (tap_count_q == '0) begin
      taps_used = fir16_pkg::TCNT_W'(1);
    end else if (tap_count_q > fir16_pkg::TCNT_W'(fir16_pkg::TAPS)) begin
      taps_used = fir16_pkg::TCNT_W'(fir16_pkg::TAPS);
    end else begin
      taps_used = tap_count_q;
    end
  end

  // stage loads: a stage takes a beat when empty or when its content moves on
  assign ld_out  = !v_out_q  || m_axis_tready_i;
  assign ld_tot  = !v_tot_q  || ld_out;
  assign ld_grp  = !v_grp_q  || ld_tot;
  assign ld_prod = !v_prod_q || ld_grp;

  assign s_axis_tready_o = ld_prod;
  assign accept          = s_axis_tvalid_i && ld_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_prod_q <= 1'b0;
      v_grp_q  <= 1'b0;
      v_tot_q  <= 1'b0;
      v_out_q  <= 1'b0;
    end else begin
      if (ld_prod) v_prod_q <= accept;
      if (ld_grp)  v_grp_q  <= v_prod_q;
      if (ld_tot)  v_tot_q  <= v_grp_q;
      if (ld_out)  v_out_q  <= v_tot_q;
    end
  end

  // chain of tap cells, the new sample enters at cell zero
  assign chain[0] = s_axis_tdata_i;

  for (genvar j = 0; j < fir16_pkg::TAPS; j++) begin : g_cell
    assign coef[j] = coef_bank_q[j / 4][(j % 4) * fir16_pkg::COEF_SLOT +: fir16_pkg::COEF_WIDTH];
    assign cell_ctrl[j].shift   = accept;
    assign cell_ctrl[j].clear   = (j != 0) && s_axis_tuser_i;
    assign cell_ctrl[j].use_tap = fir16_pkg::TCNT_W'(j) < taps_used;

    fir16_tap_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl[j]),
      .smp_i  (chain[j]),
      .coef_i (coef[j]),
      .smp_o  (chain[j+1]),
      .prod_o (prod[j])
    );
  end

  // summation
  assign sum_ctrl.ld_grp = ld_grp;
  assign sum_ctrl.ld_tot = ld_tot;

  fir16_sum_tree u_sum (
    .clk_i  (clk_i),
    .ctrl_i (sum_ctrl),
    .prod_i (prod),
    .sum_o  (sum)
  );

  // rounding, saturation and output register
  fir16_round_sat u_out (
    .clk_i     (clk_i),
    .load_i    (ld_out),
    .acc_i     (sum),
    .sample_o  (sample_out),
    .clipped_o (m_axis_tuser_o)
  );

  assign m_axis_tvalid_o = v_out_q;
  assign m_axis_tdata_o  = sample_out;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream-level testbench of the int16 fir filter
// a directed part covers rounding ties, saturation, tap count limits and
// ignored register indexes. Random segments follow, each with a tap count write,
// some coefficient banks rewritten and stream gaps as its modes pick. A scoreboard
// checks every output beat against an in-house model of the filter and its sample history.
// ----------------------------------------------------------------------------
module tb;
  import fir16_pkg::*;

  localparam int          SEGMENTS    = 16;
  localparam int          SEG_ITEMS   = 100;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam longint      SAT_MAX     = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint      SAT_MIN     = -SAT_MAX - 1;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                batch_start;
  } sample_beat_t;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                clipped;
  } filt_result_t;

  // dut ports
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [SAMPLE_W-1:0]   s_axis_tdata_i  = '0;  // [15:0] sample_in
  logic                  s_axis_tuser_i  = 1'b0; // [0] batch_start
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [SAMPLE_W-1:0]   m_axis_tdata_o;        // [15:0] sample_out
  logic                  m_axis_tuser_o;        // [0] clipped
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  // filter model state
  logic [TCNT_W-1:0]          tap_reg;
  logic [BANK_W-1:0]          coef_reg [NUM_BANKS];
  logic signed [SAMPLE_W-1:0] hist     [TAPS-1];

  // stimulus and scoreboard
  sample_beat_t sample_q[$];
  filt_result_t filtered_q[$];
  sample_beat_t beat;
  filt_result_t want;
  int           items_pushed = 0;
  int           items_taken  = 0;
  int           in_gap       = 0;
  int           out_stall    = 0;
  int           in_mode      = 0;
  int           out_mode     = 0;
  bit           in_fire      = 1'b0;
  bit           cfg_fire     = 1'b0;
  int           errors       = 0;
  int           n_results    = 0;
  int           n_clipped    = 0;
  int           n_batch      = 0;
  int           n_cfg        = 0;
  int unsigned  cycle_cnt    = 0;

  fir_filter_int16 u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // signed coefficient j from its bank slot, low COEF_WIDTH bits only
  function automatic longint coef_of(input int j);
    logic [COEF_SLOT-1:0]        slot;
    logic signed [COEF_SLOT-1:0] sv;
    slot = coef_reg[j / GRP_SIZE][(j % GRP_SIZE) * COEF_SLOT +: COEF_SLOT];
    sv   = slot << (COEF_SLOT - COEF_WIDTH);
    sv   = sv >>> (COEF_SLOT - COEF_WIDTH);
    return longint'(sv);
  endfunction

  // one filter step: clear history on a batch start, sum of products, round half
  // away from zero, saturate, then shift the history whatever the tap count
  function automatic filt_result_t fir_predict(input logic [SAMPLE_W-1:0] x_bits,
                                               input logic clr);
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] tap_in;
    longint                     acc;
    longint                     half;
    longint                     rounded;
    int                         taps_used;
    filt_result_t               res;
    x    = x_bits;
    half = longint'(1) <<< (FRAC_BITS - 1);
    if (clr) begin
      foreach (hist[i]) hist[i] = '0;
    end
    taps_used = int'(tap_reg);
    if (taps_used == 0) taps_used = 1;
    if (taps_used > TAPS) taps_used = TAPS;
    acc = 0;
    for (int j = 0; j < taps_used; j++) begin
      tap_in = (j == 0) ? x : hist[j-1];
      acc += coef_of(j) * longint'(tap_in);
    end
    if (acc < 0) rounded = -((-acc + half) >>> FRAC_BITS);
    else rounded = (acc + half) >>> FRAC_BITS;
    res.clipped = 1'b1;
    if (rounded > SAT_MAX) res.value = SAT_MAX[SAMPLE_W-1:0];
    else if (rounded < SAT_MIN) res.value = SAT_MIN[SAMPLE_W-1:0];
    else begin
      res.value   = rounded[SAMPLE_W-1:0];
      res.clipped = 1'b0;
    end
    for (int i = TAPS - 2; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = x;
    return res;
  endfunction

  // gap length: mode 0 never idles, 1 idles lightly, 2 heavily
  function automatic int gap_len(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 75) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // one coefficient slot: small, full range, an extreme or plus or minus one
  function automatic logic [COEF_SLOT-1:0] rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return COEF_SLOT'($urandom_range(0, 2047) - 1024);
    if (r < 7) return COEF_SLOT'($urandom);
    if (r == 7) return 16'h7fff;
    if (r == 8) return 16'h8000;
    return ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hc000;
  endfunction

  function automatic logic [BANK_W-1:0] rand_bank();
    logic [BANK_W-1:0] b;
    for (int k = 0; k < GRP_SIZE; k++) b[k*COEF_SLOT +: COEF_SLOT] = rand_coef();
    return b;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return SAMPLE_W'($urandom);
    if (r < 7) return SAMPLE_W'($urandom_range(0, 600) - 300);
    if (r == 7) return 16'h7fff;
    if (r == 8) return 16'h8000;
    return SAMPLE_W'($urandom_range(0, 2) - 1);
  endfunction

  // mismatch report, one line each
  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] exp_v);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d", n_results, what,
             $signed(got), $signed(exp_v));
  endtask

  task automatic push_item(input int value, input bit bs);
    sample_beat_t b;
    b.value       = value[SAMPLE_W-1:0];
    b.batch_start = bs;
    sample_q.push_back(b);
    items_pushed++;
  endtask

  // called at a falling edge; valid stays up for back-to-back writes
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_fire);
  endtask

  // wait until every sample is taken and every result has come back
  task automatic drain();
    do @(negedge clk_i);
    while (items_taken != items_pushed || filtered_q.size() != 0);
  endtask

  // sample and register handshakes, update the model and check output beats
  always @(posedge clk_i) begin
    cycle_cnt++;
    in_fire  = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    cfg_fire = rst_ni && cfg_valid_i && cfg_ready_o;
    if (cfg_fire) begin
      n_cfg++;
      case (cfg_index_i)
        REG_TAP_COUNT: tap_reg = cfg_data_i[TCNT_W-1:0];
        REG_COEF_0:    coef_reg[0] = cfg_data_i;
        REG_COEF_1:    coef_reg[1] = cfg_data_i;
        REG_COEF_2:    coef_reg[2] = cfg_data_i;
        REG_COEF_3:    coef_reg[3] = cfg_data_i;
        default: ;
      endcase
    end
    if (in_fire) begin
      filtered_q.push_back(fir_predict(s_axis_tdata_i, s_axis_tuser_i));
      items_taken++;
      if (s_axis_tuser_i) n_batch++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected beat, sample_out", m_axis_tdata_o, '0);
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata_o !== want.value)
          report_mismatch("sample_out", m_axis_tdata_o, want.value);
        if (m_axis_tuser_o !== want.clipped)
          report_mismatch("clipped", SAMPLE_W'(m_axis_tuser_o), SAMPLE_W'(want.clipped));
        if (want.clipped) n_clipped++;
      end
      n_results++;
    end
  end

  // input driver: next beat or a gap after each accepted beat
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid_i <= 1'b0;
        s_axis_tdata_i  <= SAMPLE_W'($urandom);
        s_axis_tuser_i  <= 1'($urandom);
      end else if (sample_q.size() > 0) begin
        beat = sample_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= beat.value;
        s_axis_tuser_i  <= beat.batch_start;
        in_gap = gap_len(in_mode);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      out_stall = gap_len(out_mode);
    end
  end

  // watchdog
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("Some tests failed");
    $finish;
  end

  // reset, directed part, random segments, wrap-up
  initial begin
    int seg_taps;
    tap_reg = 1;
    foreach (coef_reg[i]) coef_reg[i] = '0;
    foreach (hist[i]) hist[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: one tap with a zero coefficient
    push_item(32767, 1'b1);
    push_item(-32768, 1'b0);
    drain();

    // one-lsb coefficient: ties round away from zero
    cfg_write(REG_TAP_COUNT, 64'd1);
    cfg_write(REG_COEF_0, 64'h0001);
    cfg_valid_i <= 1'b0;
    push_item(8192, 1'b1);
    push_item(-8192, 1'b0);
    push_item(8191, 1'b0);
    push_item(-8191, 1'b0);
    push_item(24576, 1'b0);
    push_item(-24576, 1'b0);
    drain();

    // half coefficient on odd samples
    cfg_write(REG_COEF_0, 64'h2000);
    cfg_valid_i <= 1'b0;
    push_item(1, 1'b0);
    push_item(-1, 1'b0);
    push_item(3, 1'b0);
    drain();

    // all taps at the largest coefficient: saturates both ways
    cfg_write(REG_TAP_COUNT, 64'd16);
    cfg_write(REG_COEF_0, 64'h7fff_7fff_7fff_7fff);
    cfg_write(REG_COEF_1, 64'h7fff_7fff_7fff_7fff);
    cfg_write(REG_COEF_2, 64'h7fff_7fff_7fff_7fff);
    cfg_write(REG_COEF_3, 64'h7fff_7fff_7fff_7fff);
    cfg_valid_i <= 1'b0;
    push_item(32767, 1'b1);
    push_item(32767, 1'b0);
    push_item(-32768, 1'b1);
    drain();

    // all taps at the most negative coefficient
    cfg_write(REG_COEF_0, 64'h8000_8000_8000_8000);
    cfg_write(REG_COEF_1, 64'h8000_8000_8000_8000);
    cfg_write(REG_COEF_2, 64'h8000_8000_8000_8000);
    cfg_write(REG_COEF_3, 64'h8000_8000_8000_8000);
    cfg_valid_i <= 1'b0;
    push_item(32767, 1'b1);
    push_item(-32768, 1'b1);
    drain();

    // tap count of zero acts as one, upper data bits dropped
    cfg_write(REG_TAP_COUNT, 64'hffff_ffff_ffff_ffe0);
    cfg_write(REG_COEF_0, 64'h4000_c000_2000_e000);
    cfg_write(REG_COEF_1, 64'h1000_f000_0800_f800);
    cfg_write(REG_COEF_2, 64'h0400_fc00_0200_fe00);
    cfg_write(REG_COEF_3, 64'h0100_ff00_0080_ff80);
    cfg_valid_i <= 1'b0;
    push_item(1000, 1'b1);
    push_item(-2000, 1'b0);
    drain();

    // unused indexes must not touch anything; tap counts above the
    // filter length saturate, history kept from before
    for (int k = int'(REG_COEF_3) + 1; k < (1 << CFG_IDX_W); k++)
      cfg_write(CFG_IDX_W'(k), '1);
    cfg_write(REG_TAP_COUNT, 64'd31);
    cfg_valid_i <= 1'b0;
    push_item(12345, 1'b0);
    push_item(-32768, 1'b0);
    push_item(32767, 1'b0);
    drain();
    cfg_write(REG_TAP_COUNT, 64'd17);
    cfg_valid_i <= 1'b0;
    push_item(-1, 1'b0);
    drain();
    cfg_write(REG_TAP_COUNT, 64'hffff_ffff_ffff_ffe3);
    cfg_valid_i <= 1'b0;
    push_item(20000, 1'b0);
    drain();

    // random segments, each drained before the next setting
    for (int s = 0; s < SEGMENTS; s++) begin
      case (s % 4)
        0:       seg_taps = TAPS;
        1:       seg_taps = 1;
        default: seg_taps = $urandom_range(0, 31);
      endcase
      cfg_write(REG_TAP_COUNT, {$urandom, $urandom} & ~64'h1f | 64'(seg_taps));
      if ($urandom_range(0, 4) != 0) cfg_write(REG_COEF_0, rand_bank());
      if ($urandom_range(0, 4) != 0) cfg_write(REG_COEF_1, rand_bank());
      if ($urandom_range(0, 4) != 0) cfg_write(REG_COEF_2, rand_bank());
      if ($urandom_range(0, 4) != 0) cfg_write(REG_COEF_3, rand_bank());
      if ($urandom_range(0, 4) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(int'(REG_COEF_3) + 1, (1 << CFG_IDX_W) - 1)),
                  {$urandom, $urandom});
      cfg_valid_i <= 1'b0;
      in_mode  = (s < 2) ? s : $urandom_range(0, 2);
      out_mode = (s < 2) ? 2 - s : $urandom_range(0, 2);
      for (int i = 0; i < SEG_ITEMS; i++)
        push_item(int'(rand_sample()),
                  (i == 0) ? ($urandom_range(0, 1) != 0) : ($urandom_range(0, 24) == 0));
      drain();
    end

    // tail: catch any stray output beat
    repeat (12) @(posedge clk_i);
    if (filtered_q.size() != 0) report_mismatch("results left over", '0, '0);

    $display("covered %0d samples (%0d batch starts) over %0d register writes",
             items_taken, n_batch, n_cfg);
    $display("checked %0d filtered beats, %0d of them saturated", n_results, n_clipped);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
